// File: hdl/bftc_pkg.sv
// Package for the boost floor timer controller: codes, widths and a helper function.
package bftc_pkg;

  // Countdown timer width; durations above its range saturate
  localparam int TIMER_WIDTH = 16;
  localparam int DUR_WIDTH   = 16;
  localparam int FREQ_WIDTH  = 32;
  localparam int FLAG_WIDTH  = 5;
  localparam int IDX_WIDTH   = 3;

  localparam logic [31:0] TIMER_MAX32 =
    (TIMER_WIDTH >= 32) ? 32'hFFFF_FFFF : ((32'd1 << TIMER_WIDTH) - 32'd1);

  // Screen-on wake boost length in ms
  localparam logic [DUR_WIDTH-1:0] WAKE_ON_MS = DUR_WIDTH'(1000);

  typedef logic [TIMER_WIDTH-1:0] timer_t;

  // Event codes
  typedef enum logic [2:0] {
    MODE_TICK       = 3'd0,
    MODE_INPUT      = 3'd1,
    MODE_FLEX_KICK  = 3'd2,
    MODE_MAX_KICK   = 3'd3,
    MODE_WAKE_KICK  = 3'd4,
    MODE_SCREEN_ON  = 3'd5,
    MODE_SCREEN_OFF = 3'd6
  } mode_t;

  // Configuration register indexes
  typedef enum logic [IDX_WIDTH-1:0] {
    REG_INPUT_DURATION  = 3'd0,
    REG_FLEX_DURATION   = 3'd1,
    REG_FREQ_HIGH       = 3'd2,
    REG_FREQ_LOW        = 3'd3,
    REG_FLOOR_FREQ      = 3'd4,
    REG_DEVICE_ATTACHED = 3'd5
  } reg_idx_t;

  // Boost flag bit positions
  localparam int FLAG_SCREEN = 0;
  localparam int FLAG_INPUT  = 1;
  localparam int FLAG_FLEX   = 2;
  localparam int FLAG_WAKE   = 3;
  localparam int FLAG_MAX    = 4;

  // Timer pending bit positions
  localparam int TMR_INPUT = 0;
  localparam int TMR_FLEX  = 1;
  localparam int TMR_MAX   = 2;

  // Saturate a millisecond duration to the timer range
  function automatic timer_t clamp_dur(input logic [DUR_WIDTH-1:0] d);
    logic [31:0] d32;
    logic [31:0] r;
    d32 = 32'(d);
    r   = (d32 > TIMER_MAX32) ? TIMER_MAX32 : d32;
    return r[TIMER_WIDTH-1:0];
  endfunction

endpackage

// File: hdl/boost_floor_timer_controller_top.sv
// Boost floor timer controller: event decode, boost timers and floor selection.
//
// One event beat is taken per clock while in_stall is low. The event is held in an
// input register, then a single pass of decode, three timer updates and the floor
// mux writes the state and the result register when the result side is ready.
// Sustained rate is one event per cycle while the result side is not stalled;
// a stall backs up through the two registers. Configuration writes are always
// ready and should be made while no event is in flight. The screen-on flag is
// set after reset, all timers idle.
module boost_floor_timer_controller_top (
  input  logic                               clk,
  input  logic                               rst,
  // event channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [2:0]                         mode,
  input  logic [bftc_pkg::DUR_WIDTH-1:0]     boost_ms,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bftc_pkg::FREQ_WIDTH-1:0]    freq_floor,
  output logic                               max_active,
  output logic [bftc_pkg::FLAG_WIDTH-1:0]    flags,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bftc_pkg::IDX_WIDTH-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data
);
  import bftc_pkg::*;

  // configuration registers
  logic [DUR_WIDTH-1:0]  input_duration;
  logic [DUR_WIDTH-1:0]  flex_duration;
  logic [FREQ_WIDTH-1:0] freq_high;
  logic [FREQ_WIDTH-1:0] freq_low;
  logic [FREQ_WIDTH-1:0] floor_freq;
  logic                  device_attached;

  // input stage
  logic                 s1_valid;
  logic [2:0]           s1_mode;
  logic [DUR_WIDTH-1:0] s1_dur;

  // controller state
  logic [FLAG_WIDTH-1:0] boost_flags, boost_flags_next;
  timer_t                input_rem, input_rem_next;
  timer_t                flex_rem, flex_rem_next;
  timer_t                max_rem, max_rem_next;
  logic [2:0]            timer_pending, timer_pending_next;
  logic [FREQ_WIDTH-1:0] floor_next;

  logic out_ready;
  logic s1_move;
  logic in_take;
  logic dev;
  logic scr;
  logic [DUR_WIDTH-1:0] flex_dur;

  assign cfg_ready = 1'b1;
  assign out_ready = !out_valid || !out_stall;
  assign s1_move   = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;
  assign in_take   = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      input_duration  <= DUR_WIDTH'(100);
      flex_duration   <= '0;
      freq_high       <= '0;
      freq_low        <= '0;
      floor_freq      <= '0;
      device_attached <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_INPUT_DURATION:  input_duration  <= cfg_data[DUR_WIDTH-1:0];
        REG_FLEX_DURATION:   flex_duration   <= cfg_data[DUR_WIDTH-1:0];
        REG_FREQ_HIGH:       freq_high       <= cfg_data;
        REG_FREQ_LOW:        freq_low        <= cfg_data;
        REG_FLOOR_FREQ:      floor_freq      <= cfg_data;
        REG_DEVICE_ATTACHED: device_attached <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
    if (in_take) begin
      s1_mode <= mode;
      s1_dur  <= boost_ms;
    end
  end

  assign dev      = device_attached;
  assign scr      = boost_flags[FLAG_SCREEN];
  assign flex_dur = (s1_dur != '0) ? s1_dur : flex_duration;

  // event decode and timer update
  always_comb begin
    boost_flags_next   = boost_flags;
    input_rem_next     = input_rem;
    flex_rem_next      = flex_rem;
    max_rem_next       = max_rem;
    timer_pending_next = timer_pending;
    case (mode_t'(s1_mode))
      MODE_TICK: begin
        if (timer_pending[TMR_INPUT]) begin
          if (input_rem <= timer_t'(1)) begin
            input_rem_next                = '0;
            timer_pending_next[TMR_INPUT] = 1'b0;
            boost_flags_next[FLAG_INPUT]  = 1'b0;
          end else begin
            input_rem_next = input_rem - timer_t'(1);
          end
        end
        if (timer_pending[TMR_FLEX]) begin
          if (flex_rem <= timer_t'(1)) begin
            flex_rem_next                = '0;
            timer_pending_next[TMR_FLEX] = 1'b0;
            boost_flags_next[FLAG_FLEX]  = 1'b0;
          end else begin
            flex_rem_next = flex_rem - timer_t'(1);
          end
        end
        if (timer_pending[TMR_MAX]) begin
          if (max_rem <= timer_t'(1)) begin
            max_rem_next                = '0;
            timer_pending_next[TMR_MAX] = 1'b0;
            boost_flags_next[FLAG_WAKE] = 1'b0;
            boost_flags_next[FLAG_MAX]  = 1'b0;
          end else begin
            max_rem_next = max_rem - timer_t'(1);
          end
        end
      end
      MODE_INPUT: begin
        if (dev && scr) begin
          input_rem_next                = clamp_dur(input_duration);
          timer_pending_next[TMR_INPUT] = 1'b1;
          if (!timer_pending[TMR_INPUT]) boost_flags_next[FLAG_INPUT] = 1'b1;
        end
      end
      MODE_FLEX_KICK: begin
        if (dev && scr && (flex_dur != '0)) begin
          flex_rem_next                = clamp_dur(flex_dur);
          timer_pending_next[TMR_FLEX] = 1'b1;
          if (!timer_pending[TMR_FLEX]) boost_flags_next[FLAG_FLEX] = 1'b1;
        end
      end
      MODE_MAX_KICK: begin
        if (dev && scr) begin
          max_rem_next                = clamp_dur(s1_dur);
          timer_pending_next[TMR_MAX] = 1'b1;
          if (!timer_pending[TMR_MAX]) boost_flags_next[FLAG_MAX] = 1'b1;
        end
      end
      MODE_WAKE_KICK: begin
        if (dev) begin
          max_rem_next                = clamp_dur(s1_dur);
          timer_pending_next[TMR_MAX] = 1'b1;
          if (!timer_pending[TMR_MAX]) boost_flags_next[FLAG_WAKE] = 1'b1;
        end
      end
      MODE_SCREEN_ON: begin
        if (dev) begin
          max_rem_next                = clamp_dur(WAKE_ON_MS);
          timer_pending_next[TMR_MAX] = 1'b1;
          if (!timer_pending[TMR_MAX]) boost_flags_next[FLAG_WAKE] = 1'b1;
        end
        boost_flags_next[FLAG_SCREEN] = 1'b1;
      end
      MODE_SCREEN_OFF: begin
        // timers keep running, only the flags drop
        boost_flags_next = '0;
      end
      default: ;
    endcase
  end

  // floor selection: input boost over flex boost over plain floor; plain floor while the screen is off
  always_comb begin
    if (!boost_flags_next[FLAG_SCREEN]) begin
      floor_next = floor_freq;
    end else if (boost_flags_next[FLAG_INPUT]) begin
      floor_next = freq_high;
    end else if (boost_flags_next[FLAG_FLEX]) begin
      floor_next = freq_low;
    end else begin
      floor_next = floor_freq;
    end
  end

  // state commit and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      boost_flags   <= FLAG_WIDTH'(1) << FLAG_SCREEN;
      input_rem     <= '0;
      flex_rem      <= '0;
      max_rem       <= '0;
      timer_pending <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (s1_move) begin
        boost_flags   <= boost_flags_next;
        input_rem     <= input_rem_next;
        flex_rem      <= flex_rem_next;
        max_rem       <= max_rem_next;
        timer_pending <= timer_pending_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (s1_move) begin
      freq_floor <= floor_next;
      max_active <= boost_flags_next[FLAG_WAKE] || boost_flags_next[FLAG_MAX];
      flags      <= boost_flags_next;
    end
  end

  // an idle timer always holds zero
  a_idle_timer_zero: assert property (@(posedge clk) disable iff (rst)
    !timer_pending[TMR_INPUT] |-> (input_rem == '0 && !boost_flags[FLAG_INPUT]))
    else $error("input timer idle with count or flag left");

  a_flex_flag_pending: assert property (@(posedge clk) disable iff (rst)
    boost_flags[FLAG_FLEX] |-> (timer_pending[TMR_FLEX] && flex_rem != '0))
    else $error("flex flag set without a running flex timer");

  a_max_flag_pending: assert property (@(posedge clk) disable iff (rst)
    (boost_flags[FLAG_WAKE] || boost_flags[FLAG_MAX]) |-> timer_pending[TMR_MAX])
    else $error("max or wake flag set without a running max timer");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("event stalled with an empty input register");

endmodule
